/* rtl/bda_pkg.sv */
// Shared types, codes and constants of the deadlock avoidance allocator.
package bda_pkg;

   localparam int NUM_TYPES             = 3;
   localparam int UNIT_W                = 8;
   localparam int ROW_W                 = NUM_TYPES * UNIT_W;
   localparam int DEFAULT_NUM_CUSTOMERS = 8;

   typedef logic [NUM_TYPES-1:0][UNIT_W-1:0] unit_row_type;

   typedef enum logic [1:0] {
      MODE_REQUEST = 2'd0,
      MODE_RELEASE = 2'd1,
      MODE_CLAIM   = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      STS_GRANTED      = 3'd0,
      STS_EXCEEDS      = 3'd1,
      STS_LACKING      = 3'd2,
      STS_UNSAFE       = 3'd3,
      STS_RELEASED     = 3'd4,
      STS_OVER_RELEASE = 3'd5,
      STS_CLAIM_LOW    = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      CSR_TOTAL_A = 2'd0,
      CSR_TOTAL_B = 2'd1,
      CSR_TOTAL_C = 2'd2
   } csr_index_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic check;
      logic scan;
      logic decide;
      logic commit;
      logic load_rsp;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_scan;
      logic scan_last;
      logic restart;
   } dp_stat_type;

endpackage

/* rtl/bda_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bda_ram
   import bda_pkg::*;
#(
   parameter int WIDTH = ROW_W,
   parameter int DEPTH = DEFAULT_NUM_CUSTOMERS
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/bda_ctrl.sv */
// Sequencing state machine of the deadlock avoidance allocator.
module bda_ctrl
   import bda_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output ctl_cmd_type cmd,
   input  dp_stat_type stat
);

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_LOOKUP = 8'b0000_0010,
      S_CHECK  = 8'b0000_0100,
      S_SCAN   = 8'b0000_1000,
      S_DRAIN  = 8'b0001_0000,
      S_DECIDE = 8'b0010_0000,
      S_COMMIT = 8'b0100_0000,
      S_FINISH = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = stat.need_scan ? S_SCAN : S_COMMIT;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = stat.restart ? S_SCAN : S_COMMIT;
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/bda_datapath.sv */
// Tables, running sums, checks and safety scan of the allocator.
module bda_datapath
   import bda_pkg::*;
#(
   parameter int NUM_CUSTOMERS = DEFAULT_NUM_CUSTOMERS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [1:0]        req_mode,
   input  logic [2:0]        req_customer,
   input  logic [UNIT_W-1:0] req_amount_a,
   input  logic [UNIT_W-1:0] req_amount_b,
   input  logic [UNIT_W-1:0] req_amount_c,
   input  logic              csr_write,
   input  logic [1:0]        csr_index,
   input  logic [UNIT_W-1:0] csr_data,
   input  ctl_cmd_type       cmd,
   output dp_stat_type       stat,
   output logic [2:0]        rsp_status,
   output logic [UNIT_W-1:0] rsp_avail_a,
   output logic [UNIT_W-1:0] rsp_avail_b,
   output logic [UNIT_W-1:0] rsp_avail_c,
   output logic [UNIT_W-1:0] rsp_held_a,
   output logic [UNIT_W-1:0] rsp_held_b,
   output logic [UNIT_W-1:0] rsp_held_c
);

   localparam int CIDX_W = $clog2(NUM_CUSTOMERS);
   localparam int SUM_W  = UNIT_W + CIDX_W;
   localparam int WORK_W = SUM_W + 1;

   // item fields
   logic [1:0]        mode_ff;
   logic [CIDX_W-1:0] cust_ff;
   unit_row_type      amt_ff;
   logic [5:0]        cust_red;

   // configuration and running sums of holdings
   logic [NUM_TYPES-1:0][UNIT_W-1:0] total_ff;
   logic [NUM_TYPES-1:0][SUM_W-1:0]  sum_ff;
   logic [NUM_CUSTOMERS-1:0]         held_vld_ff;
   logic [NUM_CUSTOMERS-1:0]         claim_vld_ff;

   // table read port
   logic [CIDX_W-1:0] rd_addr;
   logic              rd_hvld_ff, rd_cvld_ff;
   unit_row_type      held_rd, claim_rd, held_cur, claim_cur;

   // decision registers
   status_type   status_ff;
   logic         wr_held_ff, wr_claim_ff;
   unit_row_type cur_held_ff, held_new_ff, out_held_ff;

   // safety scan
   logic [CIDX_W-1:0]                idx_ff, ev_idx_ff;
   logic                             ev_vld_ff;
   logic [NUM_CUSTOMERS-1:0]         done_ff;
   logic                             progress_ff;
   logic [NUM_TYPES-1:0][WORK_W-1:0] work_ff;
   unit_row_type                     held_e;
   logic                             fits, take;

   // check results
   logic                             over_need, lacking, over_rel, claim_low;
   logic [NUM_TYPES-1:0][UNIT_W-1:0] avail_cur, avail_tent;
   unit_row_type                     tent_row, rel_row;

   // response register
   status_type                       rsp_status_ff;
   logic [NUM_TYPES-1:0][UNIT_W-1:0] rsp_avail_ff;
   unit_row_type                     rsp_held_ff;

   // Fold the customer index into range by repeated subtraction.
   always_comb begin
      cust_red = {3'b000, req_customer};
      for (int k = 0; k < 3; k++) begin
         if (cust_red >= 6'(NUM_CUSTOMERS)) begin
            cust_red = cust_red - 6'(NUM_CUSTOMERS);
         end
      end
   end

   assign rd_addr = cmd.scan ? idx_ff : cust_ff;

   bda_ram #(.WIDTH(ROW_W), .DEPTH(NUM_CUSTOMERS)) u_held_ram (
      .clock   (clock),
      .wr_en   (cmd.commit && wr_held_ff),
      .wr_addr (cust_ff),
      .wr_data (held_new_ff),
      .rd_addr (rd_addr),
      .rd_data (held_rd)
   );

   bda_ram #(.WIDTH(ROW_W), .DEPTH(NUM_CUSTOMERS)) u_claim_ram (
      .clock   (clock),
      .wr_en   (cmd.commit && wr_claim_ff),
      .wr_addr (cust_ff),
      .wr_data (amt_ff),
      .rd_addr (rd_addr),
      .rd_data (claim_rd)
   );

   // Rows never written read as zero.
   assign held_cur  = rd_hvld_ff ? held_rd : '0;
   assign claim_cur = rd_cvld_ff ? claim_rd : '0;

   always_comb begin
      logic [UNIT_W-1:0] need_c;
      logic [SUM_W-1:0]  sum_t;
      over_need = 1'b0;
      lacking   = 1'b0;
      over_rel  = 1'b0;
      claim_low = 1'b0;
      for (int t = 0; t < NUM_TYPES; t++) begin
         need_c = (claim_cur[t] > held_cur[t]) ? claim_cur[t] - held_cur[t] : '0;
         avail_cur[t] = (SUM_W'(total_ff[t]) > sum_ff[t]) ?
                        UNIT_W'(SUM_W'(total_ff[t]) - sum_ff[t]) : '0;
         sum_t = sum_ff[t] + SUM_W'(amt_ff[t]);
         avail_tent[t] = (SUM_W'(total_ff[t]) > sum_t) ?
                         UNIT_W'(SUM_W'(total_ff[t]) - sum_t) : '0;
         tent_row[t] = held_cur[t] + amt_ff[t];
         rel_row[t]  = held_cur[t] - amt_ff[t];
         if (amt_ff[t] > need_c) over_need = 1'b1;
         if (amt_ff[t] > avail_cur[t]) lacking = 1'b1;
         if (amt_ff[t] > held_cur[t]) over_rel = 1'b1;
         if (amt_ff[t] < held_cur[t]) claim_low = 1'b1;
      end
   end

   // One customer per cycle: the tentative row stands in for the requester.
   always_comb begin
      logic [UNIT_W-1:0] need_e;
      held_e = (ev_idx_ff == cust_ff) ? held_new_ff : held_cur;
      fits   = 1'b1;
      for (int t = 0; t < NUM_TYPES; t++) begin
         need_e = (claim_cur[t] > held_e[t]) ? claim_cur[t] - held_e[t] : '0;
         if (WORK_W'(need_e) > work_ff[t]) fits = 1'b0;
      end
      take = ev_vld_ff && !done_ff[ev_idx_ff] && fits;
   end

   assign stat.need_scan = (mode_ff == MODE_REQUEST) && !over_need && !lacking;
   assign stat.scan_last = (idx_ff == CIDX_W'(NUM_CUSTOMERS - 1));
   assign stat.restart   = !(&done_ff) && progress_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         sum_ff       <= '0;
         held_vld_ff  <= '0;
         claim_vld_ff <= '0;
         ev_vld_ff    <= 1'b0;
      end else begin
         ev_vld_ff <= cmd.scan;
         if (csr_write) begin
            unique case (csr_index)
               CSR_TOTAL_A: total_ff[0] <= csr_data;
               CSR_TOTAL_B: total_ff[1] <= csr_data;
               CSR_TOTAL_C: total_ff[2] <= csr_data;
               default: ;
            endcase
         end
         if (cmd.commit && wr_held_ff) begin
            for (int t = 0; t < NUM_TYPES; t++) begin
               sum_ff[t] <= sum_ff[t] + SUM_W'(held_new_ff[t]) - SUM_W'(cur_held_ff[t]);
            end
            held_vld_ff[cust_ff] <= 1'b1;
         end
         if (cmd.commit && wr_claim_ff) begin
            claim_vld_ff[cust_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_hvld_ff <= held_vld_ff[rd_addr];
      rd_cvld_ff <= claim_vld_ff[rd_addr];
      ev_idx_ff  <= idx_ff;

      if (cmd.accept) begin
         mode_ff   <= req_mode;
         cust_ff   <= cust_red[CIDX_W-1:0];
         amt_ff[0] <= req_amount_a;
         amt_ff[1] <= req_amount_b;
         amt_ff[2] <= req_amount_c;
      end

      if (cmd.check) begin
         cur_held_ff <= held_cur;
         out_held_ff <= held_cur;
         held_new_ff <= held_cur;
         wr_held_ff  <= 1'b0;
         wr_claim_ff <= 1'b0;
         status_ff   <= STS_GRANTED;
         unique case (mode_ff)
            MODE_REQUEST: begin
               priority if (over_need) begin
                  status_ff <= STS_EXCEEDS;
               end else if (lacking) begin
                  status_ff <= STS_LACKING;
               end else begin
                  // hold as unsafe until the scan finishes every customer
                  status_ff   <= STS_UNSAFE;
                  held_new_ff <= tent_row;
               end
            end
            MODE_RELEASE: begin
               if (over_rel) begin
                  status_ff <= STS_OVER_RELEASE;
               end else begin
                  status_ff   <= STS_RELEASED;
                  held_new_ff <= rel_row;
                  out_held_ff <= rel_row;
                  wr_held_ff  <= 1'b1;
               end
            end
            MODE_CLAIM: begin
               if (claim_low) begin
                  status_ff <= STS_CLAIM_LOW;
               end else begin
                  wr_claim_ff <= 1'b1;
               end
            end
            default: ;
         endcase
      end else if (cmd.decide && (&done_ff)) begin
         status_ff   <= STS_GRANTED;
         wr_held_ff  <= 1'b1;
         out_held_ff <= held_new_ff;
      end

      // scan bookkeeping
      if (cmd.check) begin
         idx_ff      <= '0;
         done_ff     <= '0;
         progress_ff <= 1'b0;
         for (int t = 0; t < NUM_TYPES; t++) begin
            work_ff[t] <= WORK_W'(avail_tent[t]);
         end
      end else if (cmd.decide) begin
         idx_ff      <= '0;
         progress_ff <= 1'b0;
      end else begin
         if (cmd.scan) begin
            idx_ff <= idx_ff + CIDX_W'(1);
         end
         if (take) begin
            done_ff[ev_idx_ff] <= 1'b1;
            progress_ff        <= 1'b1;
            for (int t = 0; t < NUM_TYPES; t++) begin
               work_ff[t] <= work_ff[t] + WORK_W'(held_e[t]);
            end
         end
      end

      if (cmd.load_rsp) begin
         rsp_status_ff <= status_ff;
         rsp_avail_ff  <= avail_cur;
         rsp_held_ff   <= out_held_ff;
      end
   end

   assign rsp_status  = rsp_status_ff;
   assign rsp_avail_a = rsp_avail_ff[0];
   assign rsp_avail_b = rsp_avail_ff[1];
   assign rsp_avail_c = rsp_avail_ff[2];
   assign rsp_held_a  = rsp_held_ff[0];
   assign rsp_held_b  = rsp_held_ff[1];
   assign rsp_held_c  = rsp_held_ff[2];

endmodule

/* rtl/bankers_deadlock_avoidance.sv */
// Top level of the banker's algorithm deadlock avoidance allocator.
//
//   Channel  Direction  Handshake              Carries
//   req_     in         req_valid / req_ready  mode, customer, amount_a/b/c
//   rsp_     out        rsp_valid / rsp_ready  status, avail_a/b/c, held_a/b/c
//   csr_     in         csr_valid / csr_ready  csr_index (0..2 = total A..C), csr_data
//
// Sequence: release, claim, refused request and unused mode pass lookup, check, commit
// and finish before rsp_valid rises. A scanned request adds up to N scan passes,
// N = NUM_CUSTOMERS, each reading every customer row, then a drain and a decide.
// Reset clears totals, holding sums and row valid bits; no clearing pass.
// One item is in flight at a time; the result register lets the next item be
// accepted while a result waits on rsp_ready. csr_ready is always high.
module bankers_deadlock_avoidance
   import bda_pkg::*;
#(
   parameter int NUM_CUSTOMERS = DEFAULT_NUM_CUSTOMERS
) (
   input  logic              clock,
   input  logic              reset,
   // item input
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_mode,
   input  logic [2:0]        req_customer,
   input  logic [UNIT_W-1:0] req_amount_a,
   input  logic [UNIT_W-1:0] req_amount_b,
   input  logic [UNIT_W-1:0] req_amount_c,
   // result output
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [2:0]        rsp_status,
   output logic [UNIT_W-1:0] rsp_avail_a,
   output logic [UNIT_W-1:0] rsp_avail_b,
   output logic [UNIT_W-1:0] rsp_avail_c,
   output logic [UNIT_W-1:0] rsp_held_a,
   output logic [UNIT_W-1:0] rsp_held_b,
   output logic [UNIT_W-1:0] rsp_held_c,
   // configuration writes
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [UNIT_W-1:0] csr_data
);

   ctl_cmd_type cmd;
   dp_stat_type stat;

   // Totals are plain registers: take every write at once.
   assign csr_ready = 1'b1;

   // Sequence lookup, check, scan passes, commit and result load.
   bda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // Hold tables, sums, the safety scan and the result register.
   bda_datapath #(.NUM_CUSTOMERS(NUM_CUSTOMERS)) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_mode     (req_mode),
      .req_customer (req_customer),
      .req_amount_a (req_amount_a),
      .req_amount_b (req_amount_b),
      .req_amount_c (req_amount_c),
      .csr_write    (csr_valid && csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_status   (rsp_status),
      .rsp_avail_a  (rsp_avail_a),
      .rsp_avail_b  (rsp_avail_b),
      .rsp_avail_c  (rsp_avail_c),
      .rsp_held_a   (rsp_held_a),
      .rsp_held_b   (rsp_held_b),
      .rsp_held_c   (rsp_held_c)
   );

endmodule
